[src/tsw_pkg.sv]
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared constants and types of the wrapping bilinear texture sampler.
// ----------------------------------------------------------------------------
package tsw_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER = 2'd2;

    localparam logic [8:0] RST_WIDTH  = 9'd256;
    localparam logic [8:0] RST_HEIGHT = 9'd256;

    localparam logic FILTER_NEAREST  = 1'b0;
    localparam logic FILTER_BILINEAR = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam logic [1:0] ST_SAMPLE = 2'd0;
    localparam logic [1:0] ST_WRITE  = 2'd1;
    localparam logic [1:0] ST_OOB    = 2'd2;

    typedef enum logic [1:0] {
        K_NEAR  = 2'd0,
        K_BILIN = 2'd1,
        K_WRITE = 2'd2,
        K_WOOB  = 2'd3
    } t_kind;

endpackage

[src/tsw_queue.sv]
// ----------------------------------------------------------------------------
// tsw_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module tsw_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[src/tsw_front.sv]
// ----------------------------------------------------------------------------
// tsw_front
// Takes items, scales coordinates by the image size, classifies the command.
// ----------------------------------------------------------------------------
module tsw_front #(
    parameter int MAX_WIDTH  = tsw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tsw_pkg::MAX_HEIGHT_DEF,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1),
    parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT),
    parameter int CW         = 2 + 16 + WW + 16 + HW + AW + 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_opcode,
    input  logic [111:0]  i_data,
    input  logic [WW-1:0] i_w,
    input  logic [HW-1:0] i_h,
    input  logic          i_mode,
    input  logic          i_clr,
    output logic          o_push,
    output logic [CW-1:0] o_cmd,
    input  logic          i_full
);

    localparam int PXW = 16 + WW;
    localparam int PYW = 16 + HW;

    typedef struct packed {
        tsw_pkg::t_kind   kind;
        logic [PXW-1:0]   px;
        logic [PYW-1:0]   py;
        logic [AW-1:0]    waddr;
        logic [31:0]      wdata;
    } t_cmd;

    logic         r_vld;
    logic         r_op;
    logic [111:0] r_data;
    logic [7:0]   w_x;
    logic [7:0]   w_y;
    logic         w_oob;
    t_cmd         w_cmd;

    assign o_ready = !i_clr && (!r_vld || !i_full);
    assign o_push  = r_vld && !i_full;

    assign w_x   = r_data[71:64];
    assign w_y   = r_data[79:72];
    assign w_oob = (int'(w_x) >= int'(i_w)) || (int'(w_y) >= int'(i_h));

    always_comb begin
        w_cmd.px    = PXW'(r_data[15:0]) * PXW'(i_w);
        w_cmd.py    = PYW'(r_data[47:32]) * PYW'(i_h);
        w_cmd.waddr = AW'(int'(w_y) * MAX_WIDTH + int'(w_x));
        w_cmd.wdata = r_data[111:80];
        if (r_op == tsw_pkg::OP_WRITE) begin
            w_cmd.kind = w_oob ? tsw_pkg::K_WOOB : tsw_pkg::K_WRITE;
        end else begin
            w_cmd.kind = (i_mode == tsw_pkg::FILTER_BILINEAR) ? tsw_pkg::K_BILIN
                                                              : tsw_pkg::K_NEAR;
        end
    end

    assign o_cmd = CW'(w_cmd);

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op   <= i_opcode;
            r_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

endmodule

[src/tsw_back.sv]
// ----------------------------------------------------------------------------
// tsw_back
// Texel store, corner fetch sequencer, weighted accumulate and result register.
// ----------------------------------------------------------------------------
module tsw_back #(
    parameter int MAX_WIDTH  = tsw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tsw_pkg::MAX_HEIGHT_DEF,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1),
    parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT),
    parameter int CW         = 2 + 16 + WW + 16 + HW + AW + 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [WW-1:0] i_w,
    input  logic [HW-1:0] i_h,
    input  logic [CW-1:0] i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_clr,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [63:0]   o_data,
    output logic [1:0]    o_status
);

    localparam int PXW   = 16 + WW;
    localparam int PYW   = 16 + HW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    typedef struct packed {
        tsw_pkg::t_kind   kind;
        logic [PXW-1:0]   px;
        logic [PYW-1:0]   py;
        logic [AW-1:0]    waddr;
        logic [31:0]      wdata;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rdata;
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    t_state        r_state;
    t_state        n_state;
    t_cmd          w_head;
    t_cmd          r_cmd;
    logic [1:0]    r_k;
    logic          r_rvld;
    logic [32:0]   r_wgt;
    logic [40:0]   r_acc [4];

    logic          r_ovld;
    logic [63:0]   r_odata;
    logic [1:0]    r_ostat;

    logic [WW-1:0] w_cx;
    logic [WW-1:0] w_cx1;
    logic [WW-1:0] w_nx;
    logic [HW-1:0] w_cy;
    logic [HW-1:0] w_cy1;
    logic [HW-1:0] w_ny;
    logic [WW-1:0] w_x;
    logic [HW-1:0] w_y;
    logic [16:0]   w_wx;
    logic [16:0]   w_wy;
    logic [32:0]   w_wgt;
    logic [AW-1:0] w_raddr;
    logic          w_near;
    logic          w_last;
    logic          w_out_free;
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [31:0]   w_wdata;

    assign w_head     = t_cmd'(i_cmd);
    assign o_clr      = r_clr;
    assign o_pop      = (r_state == S_IDLE) && !i_empty && !r_clr;
    assign w_out_free = !r_ovld || i_ready;

    assign w_near = (r_cmd.kind == tsw_pkg::K_NEAR);
    assign w_last = w_near || (r_k == 2'd3);

    assign w_cx  = r_cmd.px[PXW-1:16];
    assign w_cx1 = w_cx + WW'(1);
    assign w_nx  = (w_cx1 == i_w) ? '0 : w_cx1;
    assign w_cy  = r_cmd.py[PYW-1:16];
    assign w_cy1 = w_cy + HW'(1);
    assign w_ny  = (w_cy1 == i_h) ? '0 : w_cy1;
    assign w_x   = r_k[0] ? w_nx : w_cx;
    assign w_y   = r_k[1] ? w_ny : w_cy;

    assign w_raddr = AW'(int'(w_y) * MAX_WIDTH + int'(w_x));

    always_comb begin
        if (w_near) begin
            w_wx = 17'h10000;
            w_wy = 17'h10000;
        end else begin
            w_wx = r_k[0] ? {1'b0, r_cmd.px[15:0]} : 17'h10000 - {1'b0, r_cmd.px[15:0]};
            w_wy = r_k[1] ? {1'b0, r_cmd.py[15:0]} : 17'h10000 - {1'b0, r_cmd.py[15:0]};
        end
    end

    assign w_wgt = 33'(w_wx) * 33'(w_wy);

    // single port: clear sweep, texel write at pop, corner read while issuing
    assign w_we    = r_clr || (o_pop && (w_head.kind == tsw_pkg::K_WRITE));
    assign w_wdata = r_clr ? 32'd0 : w_head.wdata;
    assign w_addr  = r_clr ? r_clr_addr : ((r_state == S_ISSUE) ? w_raddr : w_head.waddr);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    if (w_head.kind == tsw_pkg::K_NEAR || w_head.kind == tsw_pkg::K_BILIN) begin
                        n_state = S_ISSUE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ISSUE: begin
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rvld  <= 1'b0;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_rvld  <= (r_state == S_ISSUE);
            if (o_pop) begin
                r_k <= 2'd0;
            end else if (r_state == S_ISSUE) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= w_head;
        end
        r_wgt <= w_wgt;
        for (int c = 0; c < 4; c++) begin
            if (o_pop) begin
                r_acc[c] <= '0;
            end else if (r_rvld) begin
                r_acc[c] <= r_acc[c] + 41'(r_rdata[8*c +: 8]) * 41'(r_wgt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            for (int c = 0; c < 4; c++) begin
                if (r_cmd.kind == tsw_pkg::K_WRITE || r_cmd.kind == tsw_pkg::K_WOOB) begin
                    r_odata[16*c +: 16] <= 16'd0;
                end else begin
                    r_odata[16*c +: 16] <= 16'((r_acc[c] + 41'h800000) >> 24);
                end
            end
            case (r_cmd.kind)
                tsw_pkg::K_WRITE: r_ostat <= tsw_pkg::ST_WRITE;
                tsw_pkg::K_WOOB:  r_ostat <= tsw_pkg::ST_OOB;
                default:          r_ostat <= tsw_pkg::ST_SAMPLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_ovld <= 1'b1;
        end else if (i_ready) begin
            r_ovld <= 1'b0;
        end
    end

    assign o_valid  = r_ovld;
    assign o_data   = r_odata;
    assign o_status = r_ostat;

endmodule

[src/texture_sampler_wrap_bilinear.sv]
// ----------------------------------------------------------------------------
// texture_sampler_wrap_bilinear
// RGBA8 texture unit with repeat wrap and nearest or bilinear filtering.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser is the opcode (sample or write),
// tdata carries coordinates, texel address and texel bytes. Each item gives
// one result on the m_axis channel: four 8.8 channels in tdata, status in
// tuser. Size and filter registers are written on the cfg channel; the user
// must write them only while idle, the block does not enforce this.
// A front stage registers the item and scales coordinates by the image size;
// a two-entry queue feeds the back part, which owns the single-port texel
// memory. Each corner read uses the memory port. A write goes from idle to
// done; a nearest sample reads one corner and a bilinear sample four in the
// issue state, then drains and finishes in done before the result register.
// After reset the texel memory is swept to zero, one entry a cycle, over all
// MAX_WIDTH * MAX_HEIGHT entries (65536 at the defaults); s_axis tready is low
// meanwhile. Registers reset to 256 x 256, bilinear. When the receiver holds
// m_axis tready low the result stays put, and the front keeps taking items
// until the queue and its own register are full.
// ----------------------------------------------------------------------------
module texture_sampler_wrap_bilinear #(
    parameter int MAX_WIDTH  = tsw_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tsw_pkg::MAX_HEIGHT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // coord_u, coord_v, texel_x, texel_y, write_red, write_green,
    // write_blue, write_alpha
    input  logic [111:0] i_s_axis_tdata,
    // opcode
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [63:0]  o_m_axis_tdata,
    // status
    output logic [1:0]   o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [tsw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CW = 2 + 16 + WW + 16 + HW + AW + 32;

    logic [8:0]    r_cfg_w;
    logic [8:0]    r_cfg_h;
    logic          r_cfg_mode;
    logic [WW-1:0] w_w;
    logic [HW-1:0] w_h;
    logic          w_clr;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic [CW-1:0] w_cmd_in;
    logic [CW-1:0] w_cmd_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= tsw_pkg::RST_WIDTH;
            r_cfg_h    <= tsw_pkg::RST_HEIGHT;
            r_cfg_mode <= tsw_pkg::FILTER_BILINEAR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tsw_pkg::REG_WIDTH:  r_cfg_w    <= i_cfg_data;
                tsw_pkg::REG_HEIGHT: r_cfg_h    <= i_cfg_data;
                tsw_pkg::REG_FILTER: r_cfg_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the store size
    always_comb begin
        if (r_cfg_w == 9'd0) begin
            w_w = WW'(1);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == 9'd0) begin
            w_h = HW'(1);
        end else if (int'(r_cfg_h) > MAX_HEIGHT) begin
            w_h = HW'(MAX_HEIGHT);
        end else begin
            w_h = HW'(r_cfg_h);
        end
    end

    tsw_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .WW        (WW),
        .HW        (HW),
        .AW        (AW),
        .CW        (CW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_opcode(i_s_axis_tuser),
        .i_data  (i_s_axis_tdata),
        .i_w     (w_w),
        .i_h     (w_h),
        .i_mode  (r_cfg_mode),
        .i_clr   (w_clr),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in),
        .i_full  (w_full)
    );

    tsw_queue #(
        .DW(CW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_cmd_in),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_data (w_cmd_out),
        .o_empty(w_empty)
    );

    tsw_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .WW        (WW),
        .HW        (HW),
        .AW        (AW),
        .CW        (CW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_w     (w_w),
        .i_h     (w_h),
        .i_cmd   (w_cmd_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_clr   (w_clr),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_status(o_m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr |-> !o_s_axis_tready)
        else $error("item taken during memory clear");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue popped while empty");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue pushed while full");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == tsw_pkg::ST_WRITE ||
                             o_m_axis_tuser == tsw_pkg::ST_OOB)) |-> (o_m_axis_tdata == 64'd0))
        else $error("write result carries color data");
`endif

endmodule
